// File: hdl/rotation_matrix_to_euler_top_defines.svh
// Shared assertion macros for the rotation-matrix-to-Euler block.
`ifndef ROTATION_MATRIX_TO_EULER_TOP_DEFINES_SVH
`define ROTATION_MATRIX_TO_EULER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RMTE_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked after a delay set by the n argument.
`define RMTE_ASSERT_DELAY(label, ante, n, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error(msg);

`endif

// File: hdl/rmte_pkg.sv
package rmte_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ELEMENT_WIDTH = 16;

    // CORDIC vector width; one is 2^UNIT_SHIFT inside the rotator
    localparam int DATA_WIDTH = 48;
    localparam int UNIT_SHIFT = 44;
    // Q.20 angle accumulator width
    localparam int ANGLE_WIDTH = 25;

    localparam int PI_Q20 = 3294199;
    localparam int PI_Q13 = 25736;
    localparam int HALF_PI_Q13 = 12868;

    // Rounded atan(2^-i) in Q.20 radians
    function automatic logic signed [ANGLE_WIDTH-1:0] atan_q20(input int idx);
        logic signed [ANGLE_WIDTH-1:0] a;
        case (idx)
            0: a = 25'sd823550;
            1: a = 25'sd486170;
            2: a = 25'sd256879;
            3: a = 25'sd130396;
            4: a = 25'sd65451;
            5: a = 25'sd32757;
            6: a = 25'sd16383;
            7: a = 25'sd8192;
            8: a = 25'sd4096;
            9: a = 25'sd2048;
            10: a = 25'sd1024;
            11: a = 25'sd512;
            12: a = 25'sd256;
            13: a = 25'sd128;
            14: a = 25'sd64;
            15: a = 25'sd32;
            16: a = 25'sd16;
            17: a = 25'sd8;
            18: a = 25'sd4;
            19: a = 25'sd2;
            20: a = 25'sd1;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// File: hdl/rmte_cordic.sv
module rmte_cordic #(
    parameter int EW     = rmte_pkg::ELEMENT_WIDTH,
    parameter int STAGES = rmte_pkg::CORDIC_STAGES
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic signed [EW-1:0] y_in,
    input  logic signed [EW-1:0] x_in,
    output logic                 out_valid,
    output logic signed [15:0]   angle
);

    localparam int DW = rmte_pkg::DATA_WIDTH;
    localparam int ZW = rmte_pkg::ANGLE_WIDTH;
    localparam int SC = rmte_pkg::UNIT_SHIFT - (EW - 2);
    localparam logic signed [ZW-1:0] PI_Z = ZW'(rmte_pkg::PI_Q20);
    localparam logic signed [ZW:0] PI_MAX = (ZW+1)'(rmte_pkg::PI_Q13);
    localparam logic signed [ZW:0] PI_MIN = -(ZW+1)'(rmte_pkg::PI_Q13);

    logic [STAGES:0]        vld_reg;
    logic [STAGES:0]        zero_reg;
    logic signed [DW-1:0]   x_reg [0:STAGES];
    logic signed [DW-1:0]   y_reg [0:STAGES];
    logic signed [ZW-1:0]   z_reg [0:STAGES];
    logic                   out_valid_reg;
    logic signed [15:0]     angle_reg, angle_next;

    logic signed [DW-1:0]   xs, ys;
    logic signed [ZW:0]     zr, q;

    // Scale inputs to the vector width; the register stage below pre-rotates left half-plane vectors by pi
    always_comb
    begin
        xs = DW'(x_in) <<< SC;
        ys = DW'(y_in) <<< SC;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vld_reg       <= {vld_reg[STAGES-1:0], in_valid};
            out_valid_reg <= vld_reg[STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        zero_reg[0] <= (x_in == '0) && (y_in == '0);
        if (x_in < 0)
        begin
            x_reg[0] <= -xs;
            y_reg[0] <= -ys;
            z_reg[0] <= (y_in >= 0) ? PI_Z : -PI_Z;
        end
        else
        begin
            x_reg[0] <= xs;
            y_reg[0] <= ys;
            z_reg[0] <= '0;
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_iter
        localparam logic signed [ZW-1:0] A = rmte_pkg::atan_q20(i);
        always_ff @(posedge clk)
        begin
            zero_reg[i+1] <= zero_reg[i];
            if (y_reg[i] >= 0)
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] + A;
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] - A;
            end
        end
    end

    // Round Q.20 to Q3.13 and clamp to +-pi; a zero vector gives zero
    always_comb
    begin
        zr = (ZW+1)'(z_reg[STAGES]) + (ZW+1)'(64);
        q  = zr >>> 7;
        if (zero_reg[STAGES])
            angle_next = '0;
        else if (q > PI_MAX)
            angle_next = 16'(PI_MAX);
        else if (q < PI_MIN)
            angle_next = 16'(PI_MIN);
        else
            angle_next = 16'(q);
    end

    always_ff @(posedge clk)
    begin
        angle_reg <= angle_next;
    end

    assign out_valid = out_valid_reg;
    assign angle     = angle_reg;

endmodule

// File: hdl/rotation_matrix_to_euler_top.sv
// Z-Y-X Euler angles from a rotation matrix (Q2.14 in, Q3.13 radians out;
// pitch is Q2.13). Fully pipelined: a new matrix may be started every cycle,
// busy never rises, and each result appears on done after passing through
// the clip stage, a multiply stage, one restoring square-root stage per root
// bit for cos(pitch), and the three parallel CORDIC rotators (pre-rotation,
// one stage per iteration, rounding) plus the output register. The receiver
// cannot stall: sample the outputs on every cycle that done is high.
`include "rotation_matrix_to_euler_top_defines.svh"

module rotation_matrix_to_euler_top #(
    parameter int ELEMENT_WIDTH = rmte_pkg::ELEMENT_WIDTH,
    parameter int CORDIC_STAGES = rmte_pkg::CORDIC_STAGES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [ELEMENT_WIDTH-1:0] rot_r11,
    input  logic signed [ELEMENT_WIDTH-1:0] rot_r21,
    input  logic signed [ELEMENT_WIDTH-1:0] rot_r31,
    input  logic signed [ELEMENT_WIDTH-1:0] rot_r32,
    input  logic signed [ELEMENT_WIDTH-1:0] rot_r33,
    output logic                            done,
    output logic signed [14:0]              pitch_angle,
    output logic signed [15:0]              yaw_angle,
    output logic signed [15:0]              roll_angle,
    output logic                            gimbal_lock
);

    localparam int EW  = ELEMENT_WIDTH;
    localparam int NSQ = EW - 1;
    localparam int RW  = 2 * EW - 2;
    localparam int CL  = CORDIC_STAGES + 2;
    localparam int LAT = EW + CORDIC_STAGES + 4;
    localparam logic signed [EW-1:0] ONE = {2'b01, {(EW-2){1'b0}}};
    localparam logic signed [2*EW-1:0] ONE_SQ = (2*EW)'(ONE) * (2*EW)'(ONE);
    localparam logic signed [15:0] HALF_P = 16'(rmte_pkg::HALF_PI_Q13);
    localparam logic signed [15:0] HALF_N = -16'(rmte_pkg::HALF_PI_Q13);

    function automatic logic signed [EW-1:0] clip(input logic signed [EW-1:0] v);
        logic signed [EW-1:0] r;
        if (v > ONE)
            r = ONE;
        else if (v < -ONE)
            r = -ONE;
        else
            r = v;
        return r;
    endfunction

    // Clip stage
    logic                 a_valid_reg;
    logic signed [EW-1:0] r11_a_reg, r21_a_reg, r32_a_reg, r33_a_reg, s_a_reg;

    // Square-root line: index 0 is the multiply stage
    logic [NSQ:0]          sq_valid_reg;
    logic [RW-1:0]         rem_reg [0:NSQ];
    logic [EW-2:0]         root_reg [0:NSQ];
    logic signed [EW-1:0]  r11_q_reg [0:NSQ];
    logic signed [EW-1:0]  r21_q_reg [0:NSQ];
    logic signed [EW-1:0]  r32_q_reg [0:NSQ];
    logic signed [EW-1:0]  r33_q_reg [0:NSQ];
    logic signed [EW-1:0]  s_q_reg [0:NSQ];
    logic signed [2*EW-1:0] sq_diff;

    // Side band along the rotators
    logic [CL-1:0]         lock_reg, spos_reg;

    logic                  p_valid, y_valid, r_valid;
    logic signed [15:0]    p_ang, y_ang, r_ang;
    logic signed [EW-1:0]  c_in;
    logic                  lk_q;

    logic                  done_reg;
    logic signed [14:0]    pitch_reg, pitch_next;
    logic signed [15:0]    yaw_reg, yaw_next, roll_reg, roll_next;
    logic                  lock_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg  <= 1'b0;
            sq_valid_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            a_valid_reg  <= start && !busy;
            sq_valid_reg <= {sq_valid_reg[NSQ-1:0], a_valid_reg};
            done_reg     <= p_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        r11_a_reg <= clip(rot_r11);
        r21_a_reg <= clip(rot_r21);
        r32_a_reg <= clip(rot_r32);
        r33_a_reg <= clip(rot_r33);
        s_a_reg   <= -clip(rot_r31);
    end

    assign sq_diff = ONE_SQ - (2*EW)'(s_a_reg) * (2*EW)'(s_a_reg);

    always_ff @(posedge clk)
    begin
        rem_reg[0]   <= RW'(sq_diff);
        root_reg[0]  <= '0;
        r11_q_reg[0] <= r11_a_reg;
        r21_q_reg[0] <= r21_a_reg;
        r32_q_reg[0] <= r32_a_reg;
        r33_q_reg[0] <= r33_a_reg;
        s_q_reg[0]   <= s_a_reg;
    end

    // One root bit per stage, most significant first
    for (genvar j = 0; j < NSQ; j++)
    begin : g_sqrt
        localparam int K = NSQ - 1 - j;
        logic [RW-1:0] trial;
        assign trial = (RW'(root_reg[j]) << (K + 1)) + (RW'(1) << (2 * K));
        always_ff @(posedge clk)
        begin
            if (rem_reg[j] >= trial)
            begin
                rem_reg[j+1]  <= rem_reg[j] - trial;
                root_reg[j+1] <= root_reg[j] | ((EW-1)'(1) << K);
            end
            else
            begin
                rem_reg[j+1]  <= rem_reg[j];
                root_reg[j+1] <= root_reg[j];
            end
            r11_q_reg[j+1] <= r11_q_reg[j];
            r21_q_reg[j+1] <= r21_q_reg[j];
            r32_q_reg[j+1] <= r32_q_reg[j];
            r33_q_reg[j+1] <= r33_q_reg[j];
            s_q_reg[j+1]   <= s_q_reg[j];
        end
    end

    assign c_in = {1'b0, root_reg[NSQ]};
    assign lk_q = (s_q_reg[NSQ] == ONE) || (s_q_reg[NSQ] == -ONE);

    always_ff @(posedge clk)
    begin
        lock_reg <= {lock_reg[CL-2:0], lk_q};
        spos_reg <= {spos_reg[CL-2:0], (s_q_reg[NSQ] > 0)};
    end

    rmte_cordic #(.EW(EW), .STAGES(CORDIC_STAGES)) u_pitch (
        .clk(clk), .rst_n(rst_n), .in_valid(sq_valid_reg[NSQ]),
        .y_in(s_q_reg[NSQ]), .x_in(c_in), .out_valid(p_valid), .angle(p_ang)
    );

    rmte_cordic #(.EW(EW), .STAGES(CORDIC_STAGES)) u_yaw (
        .clk(clk), .rst_n(rst_n), .in_valid(sq_valid_reg[NSQ]),
        .y_in(r21_q_reg[NSQ]), .x_in(r11_q_reg[NSQ]), .out_valid(y_valid), .angle(y_ang)
    );

    rmte_cordic #(.EW(EW), .STAGES(CORDIC_STAGES)) u_roll (
        .clk(clk), .rst_n(rst_n), .in_valid(sq_valid_reg[NSQ]),
        .y_in(r32_q_reg[NSQ]), .x_in(r33_q_reg[NSQ]), .out_valid(r_valid), .angle(r_ang)
    );

    // Force gimbal-lock results, clamp pitch to +-pi/2
    always_comb
    begin
        if (lock_reg[CL-1])
        begin
            pitch_next = spos_reg[CL-1] ? 15'(HALF_P) : 15'(HALF_N);
            yaw_next   = '0;
            roll_next  = '0;
        end
        else
        begin
            if (p_ang > HALF_P)
                pitch_next = 15'(HALF_P);
            else if (p_ang < HALF_N)
                pitch_next = 15'(HALF_N);
            else
                pitch_next = 15'(p_ang);
            yaw_next  = y_ang;
            roll_next = r_ang;
        end
    end

    always_ff @(posedge clk)
    begin
        pitch_reg    <= pitch_next;
        yaw_reg      <= yaw_next;
        roll_reg     <= roll_next;
        lock_out_reg <= lock_reg[CL-1];
    end

    assign busy        = 1'b0;
    assign done        = done_reg;
    assign pitch_angle = pitch_reg;
    assign yaw_angle   = yaw_reg;
    assign roll_angle  = roll_reg;
    assign gimbal_lock = lock_out_reg;

    `RMTE_ASSERT_DELAY(a_latency, start && !busy, LAT, done, "result missing at fixed latency")
    `RMTE_ASSERT_IMPLY(a_lanes, p_valid, y_valid && r_valid, "rotator lanes out of step")
    `RMTE_ASSERT_IMPLY(a_lock_zero, done && gimbal_lock, yaw_angle == 0 && roll_angle == 0,
        "gimbal lock with nonzero yaw or roll")
    `RMTE_ASSERT_IMPLY(a_pitch_rng, done, pitch_angle <= HALF_P && pitch_angle >= HALF_N,
        "pitch beyond half pi")

endmodule

// File: test/tb_rotation_matrix_to_euler_top.sv
`timescale 1ns / 1ps

class euler_scoreboard;
    typedef struct {
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
        logic signed [15:0] roll;
        logic               lock;
    } angles_t;

    angles_t pending[$];
    int      errors;

    static function longint floor_shr(longint v, int n);
        return v >>> n;
    endfunction

    static function longint clip(logic signed [15:0] raw);
        longint v;
        v = raw;
        if (v > 16384) v = 16384;
        if (v < -16384) v = -16384;
        return v;
    endfunction

    static function longint atan_entry(int i);
        longint tbl [0:23];
        tbl = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                4096, 2048, 1024, 512, 256, 128, 64, 32,
                16, 8, 4, 2, 1, 0, 0, 0};
        return (i < 24) ? tbl[i] : 0;
    endfunction

    static function longint vector_angle(longint yv, longint xv);
        longint x, y, z, q, dx, dy, a;
        x = xv <<< 30;
        y = yv <<< 30;
        z = 0;
        if (xv == 0 && yv == 0) return 0;
        if (x < 0)
        begin
            z = (y >= 0) ? 3294199 : -3294199;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < rmte_pkg::CORDIC_STAGES; i++)
        begin
            a = atan_entry(i);
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (y >= 0)
            begin
                x += dx; y -= dy; z += a;
            end
            else
            begin
                x -= dx; y += dy; z -= a;
            end
        end
        q = floor_shr(z + 64, 7);
        if (q > 25736) q = 25736;
        if (q < -25736) q = -25736;
        return q;
    endfunction

    static function longint int_sqrt(longint v);
        longint r;
        r = 0;
        for (longint b = 1 << 30; b > 0; b >>= 1)
            if ((r + b) * (r + b) <= v) r += b;
        return r;
    endfunction

    function void note_request(logic signed [15:0] r11, logic signed [15:0] r21,
                               logic signed [15:0] r31, logic signed [15:0] r32,
                               logic signed [15:0] r33);
        angles_t e;
        longint s, p;
        s = -clip(r31);
        e.lock = (s == 16384 || s == -16384);
        if (e.lock)
        begin
            e.pitch = (s > 0) ? 15'sd12868 : -15'sd12868;
            e.yaw = '0;
            e.roll = '0;
        end
        else
        begin
            p = vector_angle(s, int_sqrt(16384 * 16384 - s * s));
            if (p > 12868) p = 12868;
            if (p < -12868) p = -12868;
            e.pitch = p[14:0];
            e.yaw = 16'(vector_angle(clip(r21), clip(r11)));
            e.roll = 16'(vector_angle(clip(r32), clip(r33)));
        end
        pending.push_back(e);
    endfunction

    function void check_result(logic signed [14:0] pitch, logic signed [15:0] yaw,
                               logic signed [15:0] roll, logic lock);
        angles_t e;
        if (pending.size() == 0)
        begin
            $error("unexpected result");
            errors++;
            return;
        end
        e = pending.pop_front();
        if (pitch !== e.pitch)
        begin
            $error("pitch_angle expected %0d actual %0d", e.pitch, pitch); errors++;
        end
        if (yaw !== e.yaw)
        begin
            $error("yaw_angle expected %0d actual %0d", e.yaw, yaw); errors++;
        end
        if (roll !== e.roll)
        begin
            $error("roll_angle expected %0d actual %0d", e.roll, roll); errors++;
        end
        if (lock !== e.lock)
        begin
            $error("gimbal_lock expected %0d actual %0d", e.lock, lock); errors++;
        end
    endfunction
endclass

module tb_rotation_matrix_to_euler_top;
    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    logic busy, done, gimbal_lock;
    logic signed [15:0] rot_r11 = 0, rot_r21 = 0, rot_r31 = 0, rot_r32 = 0, rot_r33 = 0;
    logic signed [14:0] pitch_angle;
    logic signed [15:0] yaw_angle, roll_angle;
    euler_scoreboard board = new();
    int idle_pct = 0;
    int stall = 0;
    int timed_out = 0;

    rotation_matrix_to_euler_top dut (.*);

    always #6 clk = ~clk;

    always @(posedge clk)
        if (rst_n && done) board.check_result(pitch_angle, yaw_angle, roll_angle, gimbal_lock);

    always @(posedge clk)
    begin
        if ((start && !busy) || done) stall = 0;
        else stall++;
        if (stall > 2000)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic signed [15:0] pick_elem();
        case ($urandom_range(0, 9))
            0: return 16'($urandom());
            1: return 16'sd16384;
            2: return -16'sd16384;
            3: return 16'sd0;
            default: return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
        endcase
    endfunction

    task automatic send_request(logic signed [15:0] a, b, c, d, e);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 0;
            @(posedge clk);
        end
        start <= 1;
        rot_r11 <= a; rot_r21 <= b; rot_r31 <= c; rot_r32 <= d; rot_r33 <= e;
        do @(posedge clk); while (busy);
        board.note_request(a, b, c, d, e);
    endtask

    initial
    begin
        logic signed [15:0] ext [0:5];
        ext = '{16'sh7fff, 16'sh8000, 16'sd16384, -16'sd16384, 16'sd0, 16'sd1};
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        for (int i = 0; i < 6; i++)
            send_request(ext[i], ext[(i + 1) % 6], ext[(i + 2) % 6], ext[(i + 3) % 6],
                         ext[(i + 4) % 6]);
        send_request(0, 0, 0, 0, 0);
        send_request(-16'sd16384, 0, 16'sd100, 0, -16'sd16384);
        send_request(-16'sd16384, -16'sd5, 16'sd16384, 16'sd7, -16'sd3);
        send_request(16'sd20000, 16'sd20000, -16'sd20000, -16'sd20000, 16'sd20000);
        send_request(16'sd16383, 16'sd1, -16'sd16383, -16'sd1, 16'sd16383);
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = (ph == 0) ? 0 : (ph == 3) ? 33 : 59;
            for (int n = 0; n < 400; n++)
                send_request(pick_elem(), pick_elem(), pick_elem(), pick_elem(), pick_elem());
        end
        start <= 0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
